@@ rtl/lobm_pkg.sv @@
// lobm_pkg: shared constants and types of the order book matcher
// no dependencies
package lobm_pkg;

  localparam int BOOK_ENTRIES = 32;
  localparam int IDX_W        = $clog2(BOOK_ENTRIES);
  localparam int PRICE_BITS   = 16;
  localparam int QTY_BITS     = 16;
  localparam int ID_W         = 63;
  localparam int FIFO_DEPTH   = 2;

  localparam logic [1:0] MODE_LIMIT  = 2'd0;
  localparam logic [1:0] MODE_MARKET = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BOOK_FULL = 2'd2;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam logic SIDE_BUY = 1'b0;

  typedef struct packed {
    logic [1:0]            mode;
    logic                  side;
    logic [PRICE_BITS-1:0] limit;
    logic [QTY_BITS-1:0]   qty;
    logic [ID_W-1:0]       cancel_id;
    logic [ID_W-1:0]       order_id;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t item;
  } queue_head_t;

endpackage

@@ rtl/lobm_if.sv @@
// lobm_req_if, lobm_res_if: request and result channels
// no dependencies
interface lobm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        side;
  logic [15:0] limit_price;
  logic [15:0] quantity;
  logic [62:0] cancel_id;
  modport source(output valid, mode, side, limit_price, quantity, cancel_id, input ready);
  modport sink(input valid, mode, side, limit_price, quantity, cancel_id, output ready);
endinterface

interface lobm_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [62:0] buyer_id;
  logic [62:0] seller_id;
  logic [15:0] fill_price;
  logic [15:0] fill_quantity;
  logic [62:0] assigned_id;
  logic [1:0]  status;
  logic        last;
  modport source(output valid, kind, buyer_id, seller_id, fill_price, fill_quantity,
                 assigned_id, status, last, input ready);
  modport sink(input valid, kind, buyer_id, seller_id, fill_price, fill_quantity,
               assigned_id, status, last, output ready);
endinterface

@@ rtl/lobm_front.sv @@
// lobm_front: accepts requests, assigns order ids, queues them for the engine
// depends on lobm_pkg, lobm_if
module lobm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  lobm_req_if.sink             in_req,
  output lobm_pkg::queue_head_t head,
  input  logic                 pop
);

  lobm_pkg::req_t             mem_r [lobm_pkg::FIFO_DEPTH];
  logic                       wr_ptr_r, rd_ptr_r;
  logic [1:0]                 count_r;
  logic [lobm_pkg::ID_W-1:0]  next_id_r;
  logic                       push;
  lobm_pkg::req_t             item;

  assign in_req.ready = (count_r != 2'(lobm_pkg::FIFO_DEPTH));
  assign push         = in_req.valid && in_req.ready;

  always_comb begin
    item.mode      = in_req.mode;
    item.side      = in_req.side;
    item.limit     = in_req.limit_price[lobm_pkg::PRICE_BITS-1:0];
    item.qty       = in_req.quantity[lobm_pkg::QTY_BITS-1:0];
    item.cancel_id = in_req.cancel_id;
    item.order_id  = next_id_r;
  end

  assign head.valid = (count_r != 2'd0);
  assign head.item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      count_r   <= 2'd0;
      next_id_r <= lobm_pkg::ID_W'(1);
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
        if (!in_req.mode[1]) begin
          next_id_r <= next_id_r + lobm_pkg::ID_W'(1);
        end
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTH
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(lobm_pkg::FIFO_DEPTH)) else $error("queue overflow");
`endif

endmodule

@@ rtl/lobm_engine.sv @@
// lobm_engine: book storage, best-entry scan, fills, resting and cancels
// depends on lobm_pkg, lobm_if
module lobm_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lobm_pkg::queue_head_t head,
  output logic                  pop,
  lobm_res_if.source            out_res
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_TRADE, S_PLACE, S_DONE} state_t;

  localparam int PW = lobm_pkg::PRICE_BITS;
  localparam int QW = lobm_pkg::QTY_BITS;
  localparam int IW = lobm_pkg::ID_W;
  localparam int XW = lobm_pkg::IDX_W;
  localparam logic [XW-1:0] LAST_IDX = XW'(lobm_pkg::BOOK_ENTRIES - 1);

  logic [lobm_pkg::BOOK_ENTRIES-1:0] ent_valid_r;
  logic          ent_side_r  [lobm_pkg::BOOK_ENTRIES];
  logic [PW-1:0] ent_price_r [lobm_pkg::BOOK_ENTRIES];
  logic [QW-1:0] ent_rem_r   [lobm_pkg::BOOK_ENTRIES];
  logic [IW-1:0] ent_id_r    [lobm_pkg::BOOK_ENTRIES];

  state_t         state_r;
  lobm_pkg::req_t cur_r;
  logic [QW-1:0]  qty_r;
  logic [XW-1:0]  scan_r, best_idx_r, free_idx_r;
  logic           found_r, free_found_r;
  logic [PW-1:0]  best_price_r;
  logic [QW-1:0]  best_rem_r;
  logic [IW-1:0]  best_id_r;
  logic [1:0]     status_r;

  logic           out_valid_r, out_kind_r, out_last_r;
  logic [IW-1:0]  out_buyer_r, out_seller_r, out_assigned_r;
  logic [15:0]    out_price_r, out_qty_r;
  logic [1:0]     out_status_r;

  logic           s_valid, s_side;
  logic [PW-1:0]  s_price;
  logic [QW-1:0]  s_rem;
  logic [IW-1:0]  s_id;
  logic           is_cancel, cancel_hit, opp, better, crosses, out_free;
  logic           do_trade, do_place, do_done;
  logic [QW-1:0]  fill;

  assign s_valid = ent_valid_r[scan_r];
  assign s_side  = ent_side_r[scan_r];
  assign s_price = ent_price_r[scan_r];
  assign s_rem   = ent_rem_r[scan_r];
  assign s_id    = ent_id_r[scan_r];

  assign is_cancel  = cur_r.mode[1];
  assign cancel_hit = (state_r == S_SCAN) && is_cancel && !found_r && s_valid
                      && (s_id == cur_r.cancel_id);
  assign opp        = s_valid && (s_side != cur_r.side);

  always_comb begin
    if (!found_r) begin
      better = 1'b1;
    end else if (s_price == best_price_r) begin
      better = s_id < best_id_r;
    end else if (cur_r.side == lobm_pkg::SIDE_BUY) begin
      better = s_price < best_price_r;
    end else begin
      better = s_price > best_price_r;
    end
  end

  always_comb begin
    if (cur_r.mode != lobm_pkg::MODE_LIMIT) begin
      crosses = found_r;
    end else if (cur_r.side == lobm_pkg::SIDE_BUY) begin
      crosses = found_r && (cur_r.limit >= best_price_r);
    end else begin
      crosses = found_r && (cur_r.limit <= best_price_r);
    end
  end

  assign out_free = !out_valid_r || out_res.ready;
  assign fill     = (qty_r < best_rem_r) ? qty_r : best_rem_r;
  assign do_trade = (state_r == S_TRADE) && out_free;
  assign do_place = (state_r == S_PLACE) && free_found_r;
  assign do_done  = (state_r == S_DONE) && out_free;
  assign pop      = (state_r == S_IDLE) && head.valid;

  // book valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= '0;
    end else begin
      if (cancel_hit) begin
        ent_valid_r[scan_r] <= 1'b0;
      end
      if (do_trade && (fill == best_rem_r)) begin
        ent_valid_r[best_idx_r] <= 1'b0;
      end
      if (do_place) begin
        ent_valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // book payload
  always_ff @(posedge clk) begin
    if (do_trade) begin
      ent_rem_r[best_idx_r] <= best_rem_r - fill;
    end
    if (do_place) begin
      ent_side_r[free_idx_r]  <= cur_r.side;
      ent_price_r[free_idx_r] <= cur_r.limit;
      ent_rem_r[free_idx_r]   <= qty_r;
      ent_id_r[free_idx_r]    <= cur_r.order_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      scan_r       <= '0;
      status_r     <= lobm_pkg::ST_OK;
    end else begin
      if (out_valid_r && out_res.ready && !do_trade && !do_done) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head.valid) begin
            cur_r        <= head.item;
            qty_r        <= head.item.qty;
            scan_r       <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            status_r     <= lobm_pkg::ST_OK;
            if (!head.item.mode[1] && (head.item.qty == '0)) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (is_cancel) begin
            if (cancel_hit) begin
              found_r <= 1'b1;
            end
          end else begin
            if (opp && better) begin
              found_r      <= 1'b1;
              best_idx_r   <= scan_r;
              best_price_r <= s_price;
              best_rem_r   <= s_rem;
              best_id_r    <= s_id;
            end
            if (!s_valid && !free_found_r) begin
              free_found_r <= 1'b1;
              free_idx_r   <= scan_r;
            end
          end
          scan_r <= scan_r + XW'(1);
          if (scan_r == LAST_IDX) begin
            if (is_cancel) begin
              status_r <= (found_r || cancel_hit) ? lobm_pkg::ST_OK : lobm_pkg::ST_NOT_FOUND;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (crosses) begin
            state_r <= S_TRADE;
          end else if (cur_r.mode == lobm_pkg::MODE_LIMIT) begin
            state_r <= S_PLACE;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_TRADE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= lobm_pkg::KIND_TRADE;
            out_buyer_r    <= (cur_r.side == lobm_pkg::SIDE_BUY) ? cur_r.order_id : best_id_r;
            out_seller_r   <= (cur_r.side == lobm_pkg::SIDE_BUY) ? best_id_r : cur_r.order_id;
            out_price_r    <= 16'(best_price_r);
            out_qty_r      <= 16'(fill);
            out_assigned_r <= '0;
            out_status_r   <= lobm_pkg::ST_OK;
            out_last_r     <= 1'b0;
            qty_r          <= qty_r - fill;
            scan_r         <= '0;
            found_r        <= 1'b0;
            free_found_r   <= 1'b0;
            state_r        <= (qty_r == fill) ? S_DONE : S_SCAN;
          end
        end
        S_PLACE: begin
          if (!free_found_r) begin
            status_r <= lobm_pkg::ST_BOOK_FULL;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_kind_r     <= lobm_pkg::KIND_DONE;
            out_buyer_r    <= '0;
            out_seller_r   <= '0;
            out_price_r    <= '0;
            out_qty_r      <= '0;
            out_assigned_r <= is_cancel ? '0 : cur_r.order_id;
            out_status_r   <= status_r;
            out_last_r     <= 1'b1;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.kind          = out_kind_r;
  assign out_res.buyer_id      = out_buyer_r;
  assign out_res.seller_id     = out_seller_r;
  assign out_res.fill_price    = out_price_r;
  assign out_res.fill_quantity = out_qty_r;
  assign out_res.assigned_id   = out_assigned_r;
  assign out_res.status        = out_status_r;
  assign out_res.last          = out_last_r;

`ifndef SYNTH
  a_trade_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRADE) |-> (found_r && ent_valid_r[best_idx_r])) else $error("trade without entry");
  a_trade_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == lobm_pkg::KIND_TRADE)) |-> (out_qty_r != '0))
    else $error("empty trade");
  a_last_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == out_kind_r)) else $error("last mismatch");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_SCAN) || (state_r == S_DONE)) else $error("bad pop");
`endif

endmodule

@@ rtl/limit_order_book_matcher_unit.sv @@
// a request enters the front queue and is popped by the engine; a book scan visits
// all BOOK_ENTRIES (32) entries, a fill costs a scan, a decide and a trade step, leftover
// limit quantity another scan, decide and place, then done; a cancel is a scan and done
// throughput: one request at a time; front queue holds two, one output register for results
// synchronous active-low reset empties the book and sets the next order id to one
// depends on lobm_pkg, lobm_if, lobm_front, lobm_engine
module limit_order_book_matcher_unit (
  input  logic clk,
  input  logic rst_n,
  lobm_req_if.sink   in_req,
  lobm_res_if.source out_res
);

  lobm_pkg::queue_head_t head;
  logic                  pop;

  lobm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .head   (head),
    .pop    (pop)
  );

  lobm_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

@@ tb/tb_limit_order_book_matcher_unit.sv @@
// tb_limit_order_book_matcher_unit: self-checking testbench of the order book matcher
// drives lobm_req_if requests, predicts trades and completions, checks lobm_res_if results
// depends on lobm_pkg, lobm_if and limit_order_book_matcher_unit
`timescale 1ns / 100ps

module tb_limit_order_book_matcher_unit;

  localparam int         IDW             = lobm_pkg::ID_W;
  localparam int         ENTRIES         = lobm_pkg::BOOK_ENTRIES;
  localparam logic [1:0] MODE_CANCEL     = 2'd2;
  localparam logic [1:0] MODE_CANCEL_ALT = 2'd3;
  localparam logic       SIDE_SELL       = 1'b1;
  localparam int         STALL_LIMIT     = 6000;
  localparam int         PRESSURE_HOLD   = 400;

  typedef struct packed {
    logic            kind;
    logic [IDW-1:0]  buyer;
    logic [IDW-1:0]  seller;
    logic [15:0]     price;
    logic [15:0]     qty;
    logic [IDW-1:0]  assigned;
    logic [1:0]      status;
    logic            last;
  } book_event_t;

  logic clk;
  logic rst_n;

  lobm_req_if req ();
  lobm_res_if res ();

  limit_order_book_matcher_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req),
    .out_res(res)
  );

  // predicted book
  logic            book_live  [ENTRIES];
  logic            book_side  [ENTRIES];
  logic [15:0]     book_price [ENTRIES];
  logic [15:0]     book_left  [ENTRIES];
  logic [IDW-1:0]  book_oid   [ENTRIES];
  logic [IDW-1:0]  next_oid;

  book_event_t     pending_events[$];
  logic [IDW-1:0]  issued_ids[$];
  int              error_count = 0;
  int              idle_cycles = 0;
  bit              gaps_on;
  int              hold_asked = 0;
  int              hold_taken;
  int              hold_left;
  int              stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int best_opposite(logic taker);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!book_live[i] || book_side[i] == taker) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (book_price[i] == book_price[best]) better = book_oid[i] < book_oid[best];
      else if (taker == lobm_pkg::SIDE_BUY) better = book_price[i] < book_price[best];
      else better = book_price[i] > book_price[best];
      if (better) best = i;
    end
    return best;
  endfunction

  function automatic book_event_t make_event(logic kind, logic [IDW-1:0] buyer,
                                             logic [IDW-1:0] seller, logic [15:0] price,
                                             logic [15:0] qty, logic [IDW-1:0] assigned,
                                             logic [1:0] status);
    book_event_t e;
    e.kind = kind; e.buyer = buyer; e.seller = seller; e.price = price; e.qty = qty;
    e.assigned = assigned; e.status = status; e.last = kind;
    return e;
  endfunction

  function automatic void add_expected(book_event_t ev);
    pending_events.insert(pending_events.size(), ev);
  endfunction

  task automatic predict_request(logic [1:0] mode, logic side, logic [15:0] limit,
                                 logic [15:0] qty, logic [IDW-1:0] target);
    logic [IDW-1:0] my_id;
    logic [1:0] status;
    logic [15:0] fill;
    int b;
    int slot;
    status = lobm_pkg::ST_OK;
    if (mode[1]) begin
      status = lobm_pkg::ST_NOT_FOUND;
      for (int i = 0; i < ENTRIES; i++) begin
        if (book_live[i] && book_oid[i] == target) begin
          book_live[i] = 1'b0;
          status = lobm_pkg::ST_OK;
          break;
        end
      end
      add_expected(make_event(lobm_pkg::KIND_DONE, '0, '0, '0, '0, '0, status));
      return;
    end
    my_id = next_oid;
    next_oid = next_oid + IDW'(1);
    issued_ids.insert(issued_ids.size(), my_id);
    while (qty != '0) begin
      b = best_opposite(side);
      if (b < 0) break;
      if (mode == lobm_pkg::MODE_LIMIT) begin
        if (side == lobm_pkg::SIDE_BUY && limit < book_price[b]) break;
        if (side == SIDE_SELL && limit > book_price[b]) break;
      end
      fill = (qty < book_left[b]) ? qty : book_left[b];
      qty -= fill;
      book_left[b] -= fill;
      if (side == lobm_pkg::SIDE_BUY)
        add_expected(make_event(lobm_pkg::KIND_TRADE, my_id, book_oid[b], book_price[b],
                                fill, '0, lobm_pkg::ST_OK));
      else
        add_expected(make_event(lobm_pkg::KIND_TRADE, book_oid[b], my_id, book_price[b],
                                fill, '0, lobm_pkg::ST_OK));
      if (book_left[b] == '0) book_live[b] = 1'b0;
    end
    if (mode == lobm_pkg::MODE_LIMIT && qty != '0) begin
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!book_live[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) status = lobm_pkg::ST_BOOK_FULL;
      else begin
        book_live[slot] = 1'b1; book_side[slot] = side; book_price[slot] = limit;
        book_left[slot] = qty; book_oid[slot] = my_id;
      end
    end
    add_expected(make_event(lobm_pkg::KIND_DONE, '0, '0, '0, '0, my_id, status));
  endtask

  task automatic send_request(logic [1:0] mode, logic side, logic [15:0] limit,
                              logic [15:0] qty, logic [IDW-1:0] target);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid = 1'b1; req.mode = mode; req.side = side; req.limit_price = limit;
    req.quantity = qty; req.cancel_id = target;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_request(mode, side, limit, qty, target);
  endtask

  task automatic send_limit(logic side, logic [15:0] limit, logic [15:0] qty);
    send_request(lobm_pkg::MODE_LIMIT, side, limit, qty, IDW'({$urandom, $urandom}));
  endtask

  task automatic pause_sender();
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  // receiver ready with random stalls and the long hold-off
  initial begin
    res.ready = 1'b0;
    hold_taken = 0;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        res.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res.ready = 1'b0;
        stall_left--;
      end else begin
        res.ready = 1'b1;
        if (gaps_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  task automatic check_field(string name, logic [IDW-1:0] exp_v, logic [IDW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    book_event_t e;
    if (rst_n && res.valid && res.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result transaction, kind %0d", res.kind);
        error_count++;
      end else begin
        e = pending_events[0];
        pending_events.delete(0);
        check_field("kind", IDW'(e.kind), IDW'(res.kind));
        check_field("buyer_id", e.buyer, res.buyer_id);
        check_field("seller_id", e.seller, res.seller_id);
        check_field("fill_price", IDW'(e.price), IDW'(res.fill_price));
        check_field("fill_quantity", IDW'(e.qty), IDW'(res.fill_quantity));
        check_field("assigned_id", e.assigned, res.assigned_id);
        check_field("status", IDW'(e.status), IDW'(res.status));
        check_field("last", IDW'(e.last), IDW'(res.last));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_empty_book();
    send_request(lobm_pkg::MODE_MARKET, lobm_pkg::SIDE_BUY, 16'd0, 16'd10, '0);
    send_request(lobm_pkg::MODE_MARKET, SIDE_SELL, 16'hffff, 16'hffff, '0);
    send_limit(lobm_pkg::SIDE_BUY, 16'd50, 16'd0);
    send_request(MODE_CANCEL, lobm_pkg::SIDE_BUY, '0, '0, {IDW{1'b1}});
    send_request(MODE_CANCEL_ALT, SIDE_SELL, 16'hffff, 16'hffff, 63'd12345);
  endtask

  task automatic test_price_time_priority();
    send_limit(SIDE_SELL, 16'd101, 16'd5);
    send_limit(SIDE_SELL, 16'd100, 16'd3);
    send_limit(SIDE_SELL, 16'd100, 16'd4);
    send_limit(lobm_pkg::SIDE_BUY, 16'd99, 16'd2);
    send_limit(lobm_pkg::SIDE_BUY, 16'd100, 16'd5);
    send_request(lobm_pkg::MODE_MARKET, lobm_pkg::SIDE_BUY, 16'd0, 16'd20, '0);
    send_limit(lobm_pkg::SIDE_BUY, 16'd0, 16'hffff);
    send_limit(SIDE_SELL, 16'hffff, 16'hffff);
    send_limit(SIDE_SELL, 16'd0, 16'hffff);
    send_request(lobm_pkg::MODE_MARKET, lobm_pkg::SIDE_BUY, 16'd0, 16'hffff, '0);
  endtask

  task automatic test_cancel();
    logic [IDW-1:0] id;
    id = next_oid;
    send_limit(lobm_pkg::SIDE_BUY, 16'd80, 16'd7);
    send_request(MODE_CANCEL, SIDE_SELL, '0, '0, id);
    send_request(MODE_CANCEL_ALT, lobm_pkg::SIDE_BUY, '0, '0, id);
  endtask

  task automatic test_book_full();
    for (int i = 0; i < ENTRIES; i++) send_limit(lobm_pkg::SIDE_BUY, 16'd1 + i[15:0], 16'd1);
    send_limit(lobm_pkg::SIDE_BUY, 16'd2, 16'd9);
    send_request(lobm_pkg::MODE_MARKET, SIDE_SELL, 16'd0, 16'hffff, '0);
  endtask

  task automatic random_request();
    int r;
    logic [IDW-1:0] target;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if ($urandom_range(0, 19) == 0)
        send_limit(1'($urandom), 16'($urandom), 16'($urandom));
      else
        send_limit(1'($urandom), 16'($urandom_range(95, 105)),
                   ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 40)));
    end else if (r < 80) begin
      send_request(lobm_pkg::MODE_MARKET, 1'($urandom), 16'($urandom),
                   16'($urandom_range(1, 60)), IDW'({$urandom, $urandom}));
    end else begin
      if (issued_ids.size() > 0 && $urandom_range(0, 4) != 0)
        target = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
      else
        target = IDW'({$urandom, $urandom});
      send_request($urandom_range(0, 1) ? MODE_CANCEL : MODE_CANCEL_ALT, 1'($urandom),
                   16'($urandom), 16'($urandom), target);
    end
  endtask

  task automatic test_random_flow(int count);
    for (int i = 0; i < count; i++) random_request();
  endtask

  task automatic test_output_backpressure();
    hold_asked++;
    for (int i = 0; i < 8; i++) send_limit(i[0], 16'd100, 16'd3);
  endtask

  initial begin
    rst_n = 1'b0;
    req.valid = 1'b0; req.mode = '0; req.side = 1'b0; req.limit_price = '0;
    req.quantity = '0; req.cancel_id = '0;
    gaps_on = 1'b1;
    next_oid = IDW'(1);
    for (int i = 0; i < ENTRIES; i++) book_live[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_book();
    test_price_time_priority();
    test_cancel();
    test_book_full();
    test_random_flow(70);
    test_output_backpressure();
    pause_sender();
    gaps_on = 1'b0;
    test_random_flow(30);
    pause_sender();

    while (pending_events.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
